### hw/rtl/fhpa_pkg.sv
// ----------------------------------------------------------------------------
// fhpa_pkg
// shared types and constants of the handle pool allocator
// ----------------------------------------------------------------------------
package fhpa_pkg;

  localparam int POOL_SIZE    = 256;
  localparam int HANDLE_SPACE = 256;
  localparam int HANDLE_W     = 8;
  localparam int COUNT_W      = 9;
  localparam int MINT_LIMIT_I = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;
  localparam logic [COUNT_W-1:0] MINT_LIMIT = COUNT_W'(MINT_LIMIT_I);
  localparam logic [COUNT_W-1:0] FIFO_DEPTH = COUNT_W'(HANDLE_SPACE);

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [COUNT_W-1:0]  count_t;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_TRY   = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NONE_FREE = 2'd1,
    STS_BAD_FREE  = 2'd2,
    STS_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

### hw/rtl/fhpa_ram.sv
// ----------------------------------------------------------------------------
// fhpa_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fhpa_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/fifo_handle_pool_allocator.sv
// ----------------------------------------------------------------------------
// fifo_handle_pool_allocator
// allocates handles from a free list fifo or a mint counter, frees into fifo
// ----------------------------------------------------------------------------
// timing: the fifo and in-use memories are read at the accepting edge and the
// result is registered in the output register once execute finds it free
// order: a new item is taken only in idle, after the read-modify-write of the
// single-port-read memories; a stalled output holds the next item in execute
// reset: pointers, counts and control clear at once; the in-use map needs no
// clearing pass since entries at or above the mint count are never consulted
module fifo_handle_pool_allocator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_handle_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_handle_out,
  output logic [1:0] out_status
);

  fhpa_pkg::state_t  state_r, state_nxt;
  fhpa_pkg::cmd_t    cmd_r;
  fhpa_pkg::handle_t hin_r;
  fhpa_pkg::handle_t rptr_r, rptr_nxt;
  fhpa_pkg::handle_t wptr_r, wptr_nxt;
  fhpa_pkg::count_t  free_count_r, free_count_nxt;
  fhpa_pkg::count_t  minted_r, minted_nxt;
  logic              out_valid_r, out_valid_nxt;
  fhpa_pkg::handle_t out_handle_r, out_handle_nxt;
  fhpa_pkg::status_t out_status_r, out_status_nxt;

  logic              accept;
  logic              out_free;
  logic              exec_go;
  fhpa_pkg::handle_t fifo_rdata;
  logic              map_rdata;
  logic              fifo_we;
  logic              map_we;
  fhpa_pkg::handle_t map_waddr;
  logic              map_wdata;

  assign in_ready = (state_r == fhpa_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign exec_go  = (state_r == fhpa_pkg::ST_EXEC) && out_free;

  fhpa_ram #(.DEPTH(fhpa_pkg::HANDLE_SPACE), .WIDTH(fhpa_pkg::HANDLE_W)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (wptr_r),
    .wdata (hin_r),
    .re    (accept),
    .raddr (rptr_r),
    .rdata (fifo_rdata)
  );

  fhpa_ram #(.DEPTH(fhpa_pkg::HANDLE_SPACE), .WIDTH(1)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (accept),
    .raddr (in_handle_in),
    .rdata (map_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    rptr_nxt       = rptr_r;
    wptr_nxt       = wptr_r;
    free_count_nxt = free_count_r;
    minted_nxt     = minted_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_handle_nxt = out_handle_r;
    out_status_nxt = out_status_r;
    fifo_we        = 1'b0;
    map_we         = 1'b0;
    map_waddr      = fifo_rdata;
    map_wdata      = 1'b1;

    if (accept) begin
      state_nxt = fhpa_pkg::ST_EXEC;
    end

    if (exec_go) begin
      state_nxt      = fhpa_pkg::ST_IDLE;
      out_valid_nxt  = 1'b1;
      out_handle_nxt = '0;
      out_status_nxt = fhpa_pkg::STS_OK;
      unique case (cmd_r)
        fhpa_pkg::CMD_ALLOC, fhpa_pkg::CMD_TRY: begin
          if (free_count_r != '0) begin
            out_handle_nxt = fifo_rdata;
            map_we         = 1'b1;
            map_waddr      = fifo_rdata;
            rptr_nxt       = rptr_r + 1'b1;
            free_count_nxt = free_count_r - 1'b1;
          end else if (cmd_r == fhpa_pkg::CMD_TRY) begin
            out_status_nxt = fhpa_pkg::STS_NONE_FREE;
          end else if (minted_r < fhpa_pkg::MINT_LIMIT) begin
            out_handle_nxt = minted_r[fhpa_pkg::HANDLE_W-1:0];
            map_we         = 1'b1;
            map_waddr      = minted_r[fhpa_pkg::HANDLE_W-1:0];
            minted_nxt     = minted_r + 1'b1;
          end else begin
            out_status_nxt = fhpa_pkg::STS_EXHAUSTED;
          end
        end
        fhpa_pkg::CMD_FREE: begin
          if (({1'b0, hin_r} >= minted_r) || !map_rdata) begin
            out_status_nxt = fhpa_pkg::STS_BAD_FREE;
          end else begin
            map_we         = 1'b1;
            map_waddr      = hin_r;
            map_wdata      = 1'b0;
            fifo_we        = 1'b1;
            wptr_nxt       = wptr_r + 1'b1;
            free_count_nxt = free_count_r + 1'b1;
          end
        end
        fhpa_pkg::CMD_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fhpa_pkg::ST_IDLE;
      rptr_r       <= '0;
      wptr_r       <= '0;
      free_count_r <= '0;
      minted_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rptr_r       <= rptr_nxt;
      wptr_r       <= wptr_nxt;
      free_count_r <= free_count_nxt;
      minted_r     <= minted_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= fhpa_pkg::cmd_t'(in_cmd);
      hin_r <= in_handle_in;
    end
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_handle_out = out_handle_r;
  assign out_status     = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= fhpa_pkg::FIFO_DEPTH)
    else $error("free list count beyond fifo depth");

  a_mint_bound: assert property (@(posedge clk) disable iff (!rst_n)
    minted_r <= fhpa_pkg::MINT_LIMIT)
    else $error("mint count beyond limit");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    fhpa_pkg::handle_t'(wptr_r - rptr_r) == free_count_r[fhpa_pkg::HANDLE_W-1:0])
    else $error("fifo pointers disagree with count");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == fhpa_pkg::ST_EXEC))
    else $error("accepted item did not enter execute");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> (out_valid_r && state_r == fhpa_pkg::ST_IDLE))
    else $error("execute did not deliver a result");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// handle pool allocator testbench: a predictor tracks the freed-handle fifo,
// the mint counter and the in-use map, and checks every result item in order
// against it while directed, random, backpressure and exhaustion tests run
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned DRAIN_WAIT  = 20;

  typedef struct packed {
    fhpa_pkg::handle_t handle;
    fhpa_pkg::status_t status;
  } grant_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_cmd = 2'd0;
  logic [7:0] in_handle_in = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_handle_out;
  logic [1:0] out_status;

  // predicted allocator state
  fhpa_pkg::handle_t fl_mem [256];
  fhpa_pkg::handle_t fl_rd = '0;
  fhpa_pkg::handle_t fl_wr = '0;
  fhpa_pkg::count_t  fl_count = '0;
  fhpa_pkg::count_t  minted = '0;
  bit                in_use [256];

  grant_t      grants_due [$];
  grant_t      seen_grant;
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  fifo_handle_pool_allocator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_handle_in   (in_handle_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_handle_out (out_handle_out),
    .out_status     (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (grants_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result item: handle %0d status %0d", out_handle_out, out_status);
      end else begin
        seen_grant = grants_due.pop_front();
        if (out_handle_out !== seen_grant.handle || out_status !== seen_grant.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected handle %0d status %0d, got handle %0d status %0d",
                     seen_grant.handle, seen_grant.status, out_handle_out, out_status);
        end
      end
    end
  end

  function automatic void pool_apply(fhpa_pkg::cmd_t c, fhpa_pkg::handle_t h);
    grant_t g;
    g.handle = '0;
    g.status = fhpa_pkg::STS_OK;
    case (c)
      fhpa_pkg::CMD_ALLOC, fhpa_pkg::CMD_TRY: begin
        if (fl_count != 0) begin
          g.handle = fl_mem[fl_rd];
          fl_rd = fl_rd + 1'b1;
          fl_count = fl_count - 1'b1;
          in_use[g.handle] = 1'b1;
        end else if (c == fhpa_pkg::CMD_TRY) begin
          g.status = fhpa_pkg::STS_NONE_FREE;
        end else if (minted < fhpa_pkg::MINT_LIMIT) begin
          g.handle = fhpa_pkg::handle_t'(minted);
          minted = minted + 1'b1;
          in_use[g.handle] = 1'b1;
        end else begin
          g.status = fhpa_pkg::STS_EXHAUSTED;
        end
      end
      fhpa_pkg::CMD_FREE: begin
        if (fhpa_pkg::count_t'(h) >= minted || !in_use[h]) begin
          g.status = fhpa_pkg::STS_BAD_FREE;
        end else begin
          in_use[h] = 1'b0;
          fl_mem[fl_wr] = h;
          fl_wr = fl_wr + 1'b1;
          fl_count = fl_count + 1'b1;
        end
      end
      default: ;
    endcase
    grants_due.push_back(g);
  endfunction

  function automatic int busy_handle();
    int start;
    start = $urandom_range(255);
    for (int i = 0; i < 256; i++)
      if (in_use[(start + i) % 256]) return (start + i) % 256;
    return -1;
  endfunction

  task automatic send_item(fhpa_pkg::cmd_t c, fhpa_pkg::handle_t h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= c;
    in_handle_in <= h;
    do @(posedge clk); while (!in_ready);
    pool_apply(c, h);
  endtask

  task automatic wait_all_granted();
    in_valid <= 1'b0;
    do @(posedge clk); while (grants_due.size() != 0);
  endtask

  task automatic random_item(output fhpa_pkg::cmd_t c, output fhpa_pkg::handle_t h);
    int unsigned r;
    int k;
    r = $urandom_range(99);
    h = fhpa_pkg::handle_t'($urandom_range(255));
    if (r < 38) begin
      c = fhpa_pkg::CMD_ALLOC;
    end else if (r < 53) begin
      c = fhpa_pkg::CMD_TRY;
    end else if (r < 94) begin
      c = fhpa_pkg::CMD_FREE;
      if ($urandom_range(9) < 8) begin
        k = busy_handle();
        if (k >= 0) h = fhpa_pkg::handle_t'(k);
      end
    end else begin
      c = fhpa_pkg::CMD_NOP;
    end
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    send_item(fhpa_pkg::CMD_TRY,   8'h00);
    send_item(fhpa_pkg::CMD_FREE,  8'h00);
    send_item(fhpa_pkg::CMD_FREE,  8'hff);
    send_item(fhpa_pkg::CMD_ALLOC, 8'hff);
    send_item(fhpa_pkg::CMD_ALLOC, 8'h55);
    send_item(fhpa_pkg::CMD_NOP,   8'hff);
    send_item(fhpa_pkg::CMD_FREE,  8'h01);
    send_item(fhpa_pkg::CMD_FREE,  8'h01);
    send_item(fhpa_pkg::CMD_FREE,  8'h02);
    send_item(fhpa_pkg::CMD_TRY,   8'haa);
    send_item(fhpa_pkg::CMD_TRY,   8'h00);
    send_item(fhpa_pkg::CMD_FREE,  8'h00);
    send_item(fhpa_pkg::CMD_FREE,  8'h01);
    send_item(fhpa_pkg::CMD_ALLOC, 8'h00);
    send_item(fhpa_pkg::CMD_ALLOC, 8'h00);
    send_item(fhpa_pkg::CMD_ALLOC, 8'h00);
    send_item(fhpa_pkg::CMD_NOP,   8'h00);
    wait_all_granted();
  endtask

  task automatic test_random_traffic(int unsigned n, int unsigned idle_pct,
                                     int unsigned stall_pct);
    int unsigned sent;
    fhpa_pkg::cmd_t c;
    fhpa_pkg::handle_t h;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < n) begin
      random_item(c, h);
      send_item(c, h);
      if (c != fhpa_pkg::CMD_NOP) sent++;
    end
    wait_all_granted();
  endtask

  task automatic test_backpressure();
    fhpa_pkg::cmd_t c;
    fhpa_pkg::handle_t h;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < 40; i++) begin
      random_item(c, h);
      send_item(c, h);
    end
    wait_all_granted();
  endtask

  task automatic test_pool_exhaustion();
    int order [256];
    int j;
    int t;
    send_idle_pct  = 21;
    sink_stall_pct = 21;
    while (minted < fhpa_pkg::MINT_LIMIT)
      send_item(fhpa_pkg::CMD_ALLOC, fhpa_pkg::handle_t'($urandom_range(255)));
    send_item(fhpa_pkg::CMD_ALLOC, fhpa_pkg::handle_t'($urandom_range(255)));
    send_item(fhpa_pkg::CMD_TRY, fhpa_pkg::handle_t'($urandom_range(255)));
    for (int i = 0; i < 256; i++) order[i] = i;
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 256; i++)
      if (in_use[order[i]]) send_item(fhpa_pkg::CMD_FREE, fhpa_pkg::handle_t'(order[i]));
    send_item(fhpa_pkg::CMD_FREE, fhpa_pkg::handle_t'(order[0]));
    while (fl_count != 0)
      send_item(fhpa_pkg::CMD_TRY, fhpa_pkg::handle_t'($urandom_range(255)));
    send_item(fhpa_pkg::CMD_TRY, fhpa_pkg::handle_t'($urandom_range(255)));
    send_item(fhpa_pkg::CMD_ALLOC, fhpa_pkg::handle_t'($urandom_range(255)));
    wait_all_granted();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(200, 0, 0);
    test_random_traffic(200, 61, 0);
    test_random_traffic(200, 0, 61);
    test_random_traffic(200, 21, 21);
    test_backpressure();
    test_pool_exhaustion();
    test_random_traffic(150, 0, 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && grants_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/fhpa_pkg.sv
hw/rtl/fhpa_ram.sv
hw/rtl/fifo_handle_pool_allocator.sv
tb/tb_top.sv
